>>> rtl/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg: shared types and constants of the timed priority command select
// Word layouts for the request, response, stored command and update control.
// ----------------------------------------------------------------------------
package tpcs_pkg;

   localparam logic        CMD_STORE      = 1'b0;
   localparam logic        CMD_TICK       = 1'b1;
   localparam logic [15:0] AGE_TOP        = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
   localparam logic [7:0]  MASK_RESET     = 8'd0;
   localparam int          MASK_W         = 8;
   localparam int          CSR_ADDR_W     = 3;
   localparam logic        REG_ACTIVE_MASK   = 1'b0;
   localparam logic        REG_TIMEOUT_TICKS = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  source_index;
      logic signed [15:0] pitch_in;
      logic signed [15:0] roll_in;
      logic signed [15:0] yaw_rate_in;
      logic signed [15:0] thrust_in;
   } req_type;

   typedef struct packed {
      logic        selected_valid;
      logic [2:0]  selected_source;
      logic signed [15:0] pitch_out;
      logic signed [15:0] roll_out;
      logic signed [15:0] yaw_rate_out;
      logic signed [15:0] thrust_out;
      logic        write_error;
   } rsp_type;

   typedef struct packed {
      logic [15:0] thrust;
      logic [15:0] yaw_rate;
      logic [15:0] roll;
      logic [15:0] pitch;
   } cmd_word_type;

   typedef struct packed {
      logic         apply;
      logic         tick;
      logic         in_range;
      logic [3:0]   index;
      cmd_word_type word;
   } upd_type;

endpackage

>>> rtl/tpcs_source_bank.sv
// ----------------------------------------------------------------------------
// tpcs_source_bank: per-source command and age registers
// Applies a store or a tick and reports the updated commands and freshness.
// ----------------------------------------------------------------------------
module tpcs_source_bank
   import tpcs_pkg::*;
#(
   parameter int NUM_SOURCES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  upd_type                         upd,
   input  logic [15:0]                     timeout,
   output cmd_word_type [NUM_SOURCES-1:0]  cmd_next,
   output logic [NUM_SOURCES-1:0]          fresh_next
);

   localparam int IdxW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   cmd_word_type [NUM_SOURCES-1:0] cmd_ff;
   cmd_word_type [NUM_SOURCES-1:0] cmd_in;
   logic [NUM_SOURCES-1:0][15:0]   age_ff;
   logic [NUM_SOURCES-1:0][15:0]   age_in;

   always_comb begin
      cmd_in = cmd_ff;
      age_in = age_ff;
      if (upd.apply) begin
         if (upd.tick == CMD_TICK) begin
            for (int s = 0; s < NUM_SOURCES; s++) begin
               if (age_ff[s] != AGE_TOP) begin
                  age_in[s] = age_ff[s] + 16'd1;
               end
            end
         end else if (upd.in_range) begin
            cmd_in[upd.index[IdxW-1:0]] = upd.word;
            age_in[upd.index[IdxW-1:0]] = '0;
         end
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
         fresh_next[s] = (age_in[s] < timeout);
      end
   end

   assign cmd_next = cmd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= '0;
         age_ff <= '0;
      end else begin
         cmd_ff <= cmd_in;
         age_ff <= age_in;
      end
   end

endmodule

>>> rtl/tpcs_priority_select.sv
// ----------------------------------------------------------------------------
// tpcs_priority_select: fixed-priority pick of the first active, fresh source
// Lowest source number wins; no qualifying source gives an all-zero result.
// ----------------------------------------------------------------------------
module tpcs_priority_select
   import tpcs_pkg::*;
#(
   parameter int NUM_SOURCES = 8
) (
   input  cmd_word_type [NUM_SOURCES-1:0]  cmd_next,
   input  logic [NUM_SOURCES-1:0]          fresh_next,
   input  logic [MASK_W-1:0]               active_mask,
   output rsp_type                         pick
);

   localparam int SelLimit = (NUM_SOURCES < MASK_W) ? NUM_SOURCES : MASK_W;

   cmd_word_type word;

   always_comb begin
      pick = '0;
      word = '0;
      for (int s = SelLimit - 1; s >= 0; s--) begin
         if (active_mask[s] && fresh_next[s]) begin
            pick.selected_valid  = 1'b1;
            pick.selected_source = 3'(s);
            word                 = cmd_next[s];
         end
      end
      pick.pitch_out    = word.pitch;
      pick.roll_out     = word.roll;
      pick.yaw_rate_out = word.yaw_rate;
      pick.thrust_out   = word.thrust;
   end

endmodule

>>> rtl/timed_priority_command_select.sv
// ----------------------------------------------------------------------------
// timed_priority_command_select: timed fixed-priority command selector
// Input register, source bank update with priority pick, result register.
// ----------------------------------------------------------------------------
// An accepted word passes from the input register to the result register.
// Throughput: one word per cycle unless stalled; the source bank updates
// once per word. A full result register with rsp_ready low stalls the input
// register, which stalls req_ready. Reset clears the pipeline, all commands
// and ages, active_mask to 0 and timeout_ticks to 500.
// ----------------------------------------------------------------------------
module timed_priority_command_select
   import tpcs_pkg::*;
#(
   parameter int NUM_SOURCES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int SelLimit = (NUM_SOURCES < MASK_W) ? NUM_SOURCES : MASK_W;

   logic [MASK_W-1:0] mask_ff;
   logic [15:0]       timeout_ff;
   logic              csr_write;

   req_type  in_ff;
   logic     in_vld_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic     rsp_vld_ff;
   logic     advance;

   upd_type                        upd;
   cmd_word_type [NUM_SOURCES-1:0] cmd_next;
   logic [NUM_SOURCES-1:0]         fresh_next;
   rsp_type                        pick;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= MASK_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_ACTIVE_MASK:   mask_ff    <= csr_pwdata[MASK_W-1:0];
            REG_TIMEOUT_TICKS: timeout_ff <= csr_pwdata[15:0];
            default:           mask_ff    <= mask_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ACTIVE_MASK:   csr_prdata = {{(32 - MASK_W){1'b0}}, mask_ff};
         REG_TIMEOUT_TICKS: csr_prdata = {16'd0, timeout_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   always_comb begin
      upd.apply         = advance;
      upd.tick          = in_ff.cmd;
      upd.in_range      = ({1'b0, in_ff.source_index} < 5'(NUM_SOURCES));
      upd.index         = in_ff.source_index;
      upd.word.pitch    = in_ff.pitch_in;
      upd.word.roll     = in_ff.roll_in;
      upd.word.yaw_rate = in_ff.yaw_rate_in;
      upd.word.thrust   = in_ff.thrust_in;
   end

   tpcs_source_bank #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_bank (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .timeout    (timeout_ff),
      .cmd_next   (cmd_next),
      .fresh_next (fresh_next)
   );

   tpcs_priority_select #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_select (
      .cmd_next    (cmd_next),
      .fresh_next  (fresh_next),
      .active_mask (mask_ff),
      .pick        (pick)
   );

   always_comb begin
      rsp_in             = pick;
      rsp_in.write_error = (in_ff.cmd == CMD_STORE) && !upd.in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.selected_valid) |->
         (rsp_ff.selected_source == 3'd0 && rsp_ff.pitch_out == 16'sd0 &&
          rsp_ff.roll_out == 16'sd0 && rsp_ff.yaw_rate_out == 16'sd0 &&
          rsp_ff.thrust_out == 16'sd0))
      else $error("empty selection carries nonzero fields");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && rsp_vld_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while pipeline is stalled");

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("advanced word did not reach the result register");

   a_source_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.selected_valid) |->
         ({1'b0, rsp_ff.selected_source} < 4'(SelLimit)))
      else $error("selected source beyond the selectable range");

endmodule

>>> sim/command_select_checker.sv
// ----------------------------------------------------------------------------
// command_select_checker: result checker for the timed priority command select
// Follows the register writes and every accepted request word, keeps its own
// copy of the stored commands and their ages, predicts the selection each word
// causes and compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module command_select_checker
   import tpcs_pkg::*;
#(
   parameter int NUM_SOURCES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]            csr_pwdata,
   input  logic                   csr_pready,
   output int                     mismatch_count,
   output int                     words_pending
);

   localparam logic [CSR_ADDR_W-1:0] MASK_ADDR    = {REG_ACTIVE_MASK, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT_TICKS, 2'b00};

   cmd_word_type held_cmd [NUM_SOURCES];
   logic [15:0]  held_age [NUM_SOURCES];
   logic [7:0]   mask_copy = MASK_RESET;
   logic [15:0]  timeout_copy = TIMEOUT_RESET;
   rsp_type      awaited_selections [$];
   int           errors = 0;

   function automatic rsp_type apply_and_select(input req_type w);
      rsp_type sel;
      bit      found;
      sel = '0;
      found = 1'b0;
      if (w.cmd == CMD_STORE) begin
         if (w.source_index >= NUM_SOURCES) begin
            sel.write_error = 1'b1;
         end else begin
            held_cmd[w.source_index].pitch    = w.pitch_in;
            held_cmd[w.source_index].roll     = w.roll_in;
            held_cmd[w.source_index].yaw_rate = w.yaw_rate_in;
            held_cmd[w.source_index].thrust   = w.thrust_in;
            held_age[w.source_index] = '0;
         end
      end else begin
         for (int s = 0; s < NUM_SOURCES; s++) begin
            if (held_age[s] != AGE_TOP) begin
               held_age[s] = held_age[s] + 16'd1;
            end
         end
      end
      for (int s = 0; s < NUM_SOURCES; s++) begin
         if (!found && s < MASK_W && mask_copy[s] && held_age[s] < timeout_copy) begin
            found = 1'b1;
            sel.selected_valid  = 1'b1;
            sel.selected_source = 3'(s);
            sel.pitch_out       = held_cmd[s].pitch;
            sel.roll_out        = held_cmd[s].roll;
            sel.yaw_rate_out    = held_cmd[s].yaw_rate;
            sel.thrust_out      = held_cmd[s].thrust;
         end
      end
      return sel;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mask_copy = MASK_RESET;
         timeout_copy = TIMEOUT_RESET;
         for (int s = 0; s < NUM_SOURCES; s++) begin
            held_cmd[s] = '0;
            held_age[s] = '0;
         end
         awaited_selections.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == MASK_ADDR) begin
               mask_copy = csr_pwdata[MASK_W-1:0];
            end else if (csr_paddr == TIMEOUT_ADDR) begin
               timeout_copy = csr_pwdata[15:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_selections.size() == 0) begin
               $error("result word arrived with no prediction waiting");
               errors++;
            end else begin
               want = awaited_selections.pop_front();
               check_field("selected_valid", 16'(want.selected_valid),
                           16'(rsp_data.selected_valid));
               check_field("selected_source", 16'(want.selected_source),
                           16'(rsp_data.selected_source));
               check_field("pitch_out", want.pitch_out, rsp_data.pitch_out);
               check_field("roll_out", want.roll_out, rsp_data.roll_out);
               check_field("yaw_rate_out", want.yaw_rate_out, rsp_data.yaw_rate_out);
               check_field("thrust_out", want.thrust_out, rsp_data.thrust_out);
               check_field("write_error", 16'(want.write_error),
                           16'(rsp_data.write_error));
            end
         end
         if (req_valid && req_ready) begin
            awaited_selections.push_back(apply_and_select(req_data));
         end
      end
      words_pending  <= awaited_selections.size();
      mismatch_count <= errors;
   end

endmodule

>>> sim/timed_priority_command_select_test.sv
// ----------------------------------------------------------------------------
// timed_priority_command_select_test: testbench top of the command selector
// Drives directed and random request words and register settings, throttles
// both channels at random, and reports the checker's verdict at the end.
// ----------------------------------------------------------------------------
module timed_priority_command_select_test;
   import tpcs_pkg::*;

   localparam int NUM_SOURCES      = 8;
   localparam int LONG_HOLD        = 120;
   localparam int AGING_TICKS      = 30;
   localparam int PHASE_WORDS      = 78;

   localparam logic [CSR_ADDR_W-1:0] MASK_ADDR    = {REG_ACTIVE_MASK, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT_TICKS, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    words_pending;
   bit                    calm = 1'b0;
   bit                    hold_due = 1'b0;

   timed_priority_command_select #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   command_select_checker #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int idle_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type store_word(input logic [3:0] idx, input logic [15:0] pitch,
                                          input logic [15:0] roll, input logic [15:0] yaw,
                                          input logic [15:0] thrust);
      req_type w;
      w.cmd          = CMD_STORE;
      w.source_index = idx;
      w.pitch_in     = pitch;
      w.roll_in      = roll;
      w.yaw_rate_in  = yaw;
      w.thrust_in    = thrust;
      return w;
   endfunction

   function automatic req_type random_store(input logic [3:0] idx);
      return store_word(idx, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   function automatic req_type tick_word();
      req_type w;
      w = random_store(4'($urandom));
      w.cmd = CMD_TICK;
      return w;
   endfunction

   task automatic offer(input req_type w);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] mask, input logic [15:0] timeout);
      write_reg(MASK_ADDR, 32'(mask));
      write_reg(TIMEOUT_ADDR, 32'(timeout));
   endtask

   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_due) begin
            stall = LONG_HOLD;
            hold_due = 1'b0;
         end else begin
            stall = idle_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: nothing is active, so nothing is ever selected.
      offer(store_word(4'd0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));
      offer(tick_word());
      offer(random_store(4'd8));
      offer(random_store(4'd15));
      settle();

      // Timeout of one: one tick makes every source stale.
      configure(8'hFF, 16'd1);
      offer(store_word(4'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      offer(store_word(4'd3, 16'h8000, 16'h0001, 16'hFFFE, 16'h5A5A));
      offer(tick_word());
      offer(random_store(4'd5));
      offer(random_store(4'd15));
      offer(store_word(4'd0, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF));
      offer(tick_word());
      settle();

      configure(8'h80, 16'hFFFF);
      offer(tick_word());
      offer(random_store(4'd7));
      offer(tick_word());
      offer(random_store(4'd1));
      settle();

      configure(8'hFF, 16'd0);
      offer(random_store(4'd2));
      offer(tick_word());
      settle();

      // Age one source across its timeout so that it turns stale.
      configure(8'h01, 16'd20);
      calm = 1'b1;
      offer(random_store(4'd0));
      repeat (AGING_TICKS) offer(tick_word());
      settle();
      calm = 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(8'hFF, 16'hFFFF);
            1: configure(8'($urandom), 16'd1);
            5: configure(8'($urandom), 16'($urandom_range(41, 65534)));
            default: configure(8'($urandom_range(1, 255)), 16'($urandom_range(2, 40)));
         endcase
         hold_due = (phase == 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               offer(tick_word());
            end else if (pick < 88) begin
               offer(random_store(4'($urandom_range(0, NUM_SOURCES - 1))));
            end else begin
               offer(random_store(4'($urandom_range(NUM_SOURCES, 15))));
            end
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/tpcs_pkg.sv
rtl/tpcs_source_bank.sv
rtl/tpcs_priority_select.sv
rtl/timed_priority_command_select.sv
sim/command_select_checker.sv
sim/timed_priority_command_select_test.sv
